// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands shared by the checkers of this block.
// Each macro samples on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and fixed constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam int LEN_W    = 63;
    localparam int CFG_IDX_W = 1;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_FLAGS     = 3'd0;
    localparam logic [2:0] ERR_UNMASKED  = 3'd1;
    localparam logic [2:0] ERR_CONTROL   = 3'd2;
    localparam logic [2:0] ERR_LEN_MSB   = 3'd3;
    localparam logic [2:0] ERR_NONCANON  = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd5;
    localparam logic [2:0] ERR_CLOSE_LEN = 3'd6;

    // Opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Length markers and limits
    localparam logic [6:0]       MAX_CTRL_LEN = 7'd125;
    localparam logic [6:0]       LEN16_MARK   = 7'd126;
    localparam logic [6:0]       LEN64_MARK   = 7'd127;
    localparam logic [LEN_W-1:0] MIN_LEN16    = 63'd126;
    localparam logic [LEN_W-1:0] MAX_LEN16    = 63'd65535;
    localparam logic [LEN_W-1:0] CLOSE_BAD_LEN = 63'd1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 1'b1;
    localparam logic [LEN_W-1:0]     MAX_PAYLOAD_RST  = 63'd1048576;

    typedef struct packed {
        logic             require_mask;
        logic [LEN_W-1:0] max_payload_size;
    } wsd_cfg_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             fin_bit;
        logic [3:0]       frame_opcode;
        logic             was_masked;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       data_byte;
        logic             last;
        logic [2:0]       error_code;
    } wsd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsd_byte_if.sv =====
// ----------------------------------------------------------------------------
// wsd_byte_if
// Byte stream channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wsd_result_if.sv =====
// ----------------------------------------------------------------------------
// wsd_result_if
// Result channel: valid/ready handshake with one decoded result.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_result_if
    import wsd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic             fin_bit;
    logic [3:0]       frame_opcode;
    logic             was_masked;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
    logic             last;
    logic [2:0]       error_code;

    modport source (
        output valid, output kind, output fin_bit, output frame_opcode,
        output was_masked, output payload_length, output data_byte,
        output last, output error_code, input ready
    );
    modport sink (
        input valid, input kind, input fin_bit, input frame_opcode,
        input was_masked, input payload_length, input data_byte,
        input last, input error_code, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/wsd_parse.sv =====
// ----------------------------------------------------------------------------
// wsd_parse
// Front end: takes one byte per transfer, runs the header checks, unmasks
// payload bytes and pushes at most one result per byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parse
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire wsd_cfg_t    cfg,
    input  wire logic        space,
    wsd_byte_if.sink         in_ch,
    output      logic        push,
    output      wsd_result_t push_res
);

    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DEAD    = 3'd5;

    logic [2:0]       phase_reg,    phase_next;
    logic             fin_reg,      fin_next;
    logic [3:0]       opcode_reg,   opcode_next;
    logic             masked_reg,   masked_next;
    logic             wide_reg,     wide_next;
    logic [3:0]       len_left_reg, len_left_next;
    logic [LEN_W-1:0] accum_reg,    accum_next;
    logic [1:0]       key_cnt_reg,  key_cnt_next;
    logic [1:0]       key_idx_reg,  key_idx_next;
    logic [LEN_W-1:0] pay_left_reg, pay_left_next;
    logic [7:0]       key_reg [4];

    logic             fire;
    logic [7:0]       b;
    logic [6:0]       marker;
    logic             op_ok;
    logic [LEN_W-1:0] acc_shift;
    logic [LEN_W-1:0] len_cand;
    logic [LEN_W-1:0] hdr_len;
    logic             masked_cand;
    logic             noncanon;
    logic             too_large;
    logic             close_one;
    logic             key_we;
    logic             do_len;
    logic             do_hdr;
    logic             pay_last;
    logic [7:0]       pay_byte;

    function automatic wsd_result_t err_res(input logic [2:0] code);
        wsd_result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    assign fire        = in_ch.valid && in_ch.ready;
    assign in_ch.ready = space;
    assign b           = in_ch.in_byte;
    assign marker      = b[6:0];
    assign op_ok       = (b[3:0] == OP_CONT) || (b[3:0] == OP_TEXT) || (b[3:0] == OP_BIN) ||
                         (b[3:0] == OP_CLOSE) || (b[3:0] == OP_PING) || (b[3:0] == OP_PONG);
    assign acc_shift   = {accum_reg[LEN_W-9:0], b};
    assign len_cand    = (phase_reg == PH_BYTE1) ? {{(LEN_W-7){1'b0}}, marker} : acc_shift;
    assign hdr_len     = (phase_reg == PH_KEY) ? accum_reg : len_cand;
    assign masked_cand = (phase_reg == PH_BYTE1) ? b[7] : masked_reg;
    assign noncanon    = wide_reg ? (acc_shift <= MAX_LEN16) : (acc_shift < MIN_LEN16);
    assign too_large   = len_cand > cfg.max_payload_size;
    assign close_one   = (opcode_reg == OP_CLOSE) && (hdr_len == CLOSE_BAD_LEN);
    assign pay_last    = pay_left_reg == {{(LEN_W-1){1'b0}}, 1'b1};
    assign pay_byte    = masked_reg ? (b ^ key_reg[key_idx_reg]) : b;

    always_comb
    begin
        phase_next    = phase_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        wide_next     = wide_reg;
        len_left_next = len_left_reg;
        accum_next    = accum_reg;
        key_cnt_next  = key_cnt_reg;
        key_idx_next  = key_idx_reg;
        pay_left_next = pay_left_reg;
        key_we        = 1'b0;
        do_len        = 1'b0;
        do_hdr        = 1'b0;
        push          = 1'b0;
        push_res      = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_BYTE0:
                begin
                    fin_next    = b[7];
                    opcode_next = b[3:0];
                    masked_next = 1'b0;
                    if ((b[6:4] != 3'd0) || !op_ok)
                    begin
                        push       = 1'b1;
                        push_res   = err_res(ERR_FLAGS);
                        phase_next = PH_DEAD;
                    end
                    else
                    begin
                        phase_next = PH_BYTE1;
                    end
                end
                PH_BYTE1:
                begin
                    masked_next = b[7];
                    if (cfg.require_mask && !b[7])
                    begin
                        push       = 1'b1;
                        push_res   = err_res(ERR_UNMASKED);
                        phase_next = PH_DEAD;
                    end
                    else if (opcode_reg[3] && (!fin_reg || (marker > MAX_CTRL_LEN)))
                    begin
                        push       = 1'b1;
                        push_res   = err_res(ERR_CONTROL);
                        phase_next = PH_DEAD;
                    end
                    else if (marker >= LEN16_MARK)
                    begin
                        accum_next    = '0;
                        wide_next     = marker == LEN64_MARK;
                        len_left_next = (marker == LEN64_MARK) ? 4'd8 : 4'd2;
                        phase_next    = PH_EXTLEN;
                    end
                    else
                    begin
                        accum_next = len_cand;
                        do_len     = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    if (wide_reg && (len_left_reg == 4'd8) && b[7])
                    begin
                        push       = 1'b1;
                        push_res   = err_res(ERR_LEN_MSB);
                        phase_next = PH_DEAD;
                    end
                    else
                    begin
                        accum_next    = acc_shift;
                        len_left_next = len_left_reg - 4'd1;
                        if (len_left_reg == 4'd1)
                        begin
                            if (noncanon)
                            begin
                                push       = 1'b1;
                                push_res   = err_res(ERR_NONCANON);
                                phase_next = PH_DEAD;
                            end
                            else
                            begin
                                do_len = 1'b1;
                            end
                        end
                    end
                end
                PH_KEY:
                begin
                    key_we       = 1'b1;
                    key_cnt_next = key_cnt_reg + 2'd1;
                    do_hdr       = key_cnt_reg == 2'd3;
                end
                PH_PAYLOAD:
                begin
                    push                    = 1'b1;
                    push_res.kind           = KIND_PAYLOAD;
                    push_res.fin_bit        = fin_reg;
                    push_res.frame_opcode   = opcode_reg;
                    push_res.was_masked     = masked_reg;
                    push_res.data_byte      = pay_byte;
                    push_res.last           = pay_last;
                    key_idx_next            = key_idx_reg + 2'd1;
                    pay_left_next           = pay_left_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    if (pay_last)
                    begin
                        phase_next = PH_BYTE0;
                    end
                end
                PH_DEAD:
                begin
                    // drop every byte until reset
                end
                default:
                begin
                    phase_next = PH_DEAD;
                end
            endcase

            // length known: size limit, then the key or the header result
            if (do_len)
            begin
                if (too_large)
                begin
                    push       = 1'b1;
                    push_res   = err_res(ERR_TOO_LARGE);
                    phase_next = PH_DEAD;
                end
                else if (masked_cand)
                begin
                    key_cnt_next = 2'd0;
                    phase_next   = PH_KEY;
                end
                else
                begin
                    do_hdr = 1'b1;
                end
            end

            if (do_hdr)
            begin
                push = 1'b1;
                if (close_one)
                begin
                    push_res   = err_res(ERR_CLOSE_LEN);
                    phase_next = PH_DEAD;
                end
                else
                begin
                    push_res.kind           = KIND_HEADER;
                    push_res.fin_bit        = fin_reg;
                    push_res.frame_opcode   = opcode_reg;
                    push_res.was_masked     = masked_cand;
                    push_res.payload_length = hdr_len;
                    push_res.last           = hdr_len == '0;
                    pay_left_next           = hdr_len;
                    key_idx_next            = 2'd0;
                    phase_next              = (hdr_len == '0) ? PH_BYTE0 : PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_BYTE0;
            fin_reg      <= 1'b0;
            opcode_reg   <= 4'd0;
            masked_reg   <= 1'b0;
            wide_reg     <= 1'b0;
            len_left_reg <= 4'd0;
            accum_reg    <= '0;
            key_cnt_reg  <= 2'd0;
            key_idx_reg  <= 2'd0;
            pay_left_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            wide_reg     <= wide_next;
            len_left_reg <= len_left_next;
            accum_reg    <= accum_next;
            key_cnt_reg  <= key_cnt_next;
            key_idx_reg  <= key_idx_next;
            pay_left_reg <= pay_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg[key_cnt_reg] <= b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wsd_queue.sv =====
// ----------------------------------------------------------------------------
// wsd_queue
// Back end: short result queue that drives the output channel, so the
// parser keeps taking bytes while a result waits for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_queue
    import wsd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire wsd_result_t push_res,
    output      logic        space,
    wsd_result_if.source     out_ch
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wsd_result_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    wsd_result_t      head;

    assign space = count_reg != FULL_CNT;
    assign pop   = out_ch.valid && out_ch.ready;
    assign head  = entry_reg[rd_ptr_reg];

    assign out_ch.valid          = count_reg != '0;
    assign out_ch.kind           = head.kind;
    assign out_ch.fin_bit        = head.fin_bit;
    assign out_ch.frame_opcode   = head.frame_opcode;
    assign out_ch.was_masked     = head.was_masked;
    assign out_ch.payload_length = head.payload_length;
    assign out_ch.data_byte      = head.data_byte;
    assign out_ch.last           = head.last;
    assign out_ch.error_code     = head.error_code;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-serial decoder for back-to-back WebSocket frames.
//
// in_ch carries the received stream, one byte per transfer. out_ch carries
// one result per header (after the last header byte, key included), one per
// payload byte (unmasked, last marked) and one on a protocol error.
// cfg_we/cfg_index/cfg_data write require_mask (index 0) and
// max_payload_size (index 1); write them only while no frame is in flight.
// A byte is taken every cycle while the queue has space; its result, if any,
// is queued for out_ch behind earlier results. Throughput, with queue space,
// is one byte per cycle, set by the parser handling one stream byte per clock.
// A result queue of QUEUE_DEPTH entries sits between parser and output.
// When the receiver stalls the queue fills and in_ch.ready drops once it
// is full; nothing is lost. After an error result the block drops all
// further bytes and stays silent until reset.
// Reset empties the queue, puts the parser at the first header byte and
// sets require_mask to 1 and max_payload_size to 1048576.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wsd_byte_if.sink                  in_ch,
    wsd_result_if.source              out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    logic             require_mask_reg;
    logic [LEN_W-1:0] max_payload_reg;
    wsd_cfg_t         cfg;
    logic             space;
    logic             push;
    wsd_result_t      push_res;

    assign cfg.require_mask     = require_mask_reg;
    assign cfg.max_payload_size = max_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_mask_reg <= 1'b1;
            max_payload_reg  <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REQUIRE_MASK: require_mask_reg <= cfg_data[0];
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    wsd_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .space    (space),
        .in_ch    (in_ch),
        .push     (push),
        .push_res (push_res)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .space    (space),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

// ===== rtl/core/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsd_checker
    import wsd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [1:0]       kind,
    input wire logic             fin_bit,
    input wire logic [3:0]       frame_opcode,
    input wire logic             was_masked,
    input wire logic [LEN_W-1:0] payload_length,
    input wire logic [7:0]       data_byte,
    input wire logic             last,
    input wire logic [2:0]       error_code
);

    logic out_xfer;
    logic err_show;

    assign out_xfer = out_valid && out_ready;
    assign err_show = out_valid && (kind == KIND_ERROR);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_byte) && $stable(payload_length) && $stable(last), "stalled result changed")
    `ASSERT_IMPLIES(a_err_clean, clk, rst_n, err_show, !last && !fin_bit && (frame_opcode == 4'd0) && !was_masked && (payload_length == '0) && (data_byte == 8'd0), "error result carries frame fields")
    `ASSERT_NEXT(a_silent_after_err, clk, rst_n, out_xfer && (kind == KIND_ERROR), !out_valid, "result after protocol error")
    `ASSERT_IMPLIES(a_hdr_last, clk, rst_n, out_valid && (kind == KIND_HEADER), last == (payload_length == '0), "header last flag disagrees with length")
    `ASSERT_IMPLIES(a_code_zero, clk, rst_n, out_valid && (kind != KIND_ERROR), error_code == ERR_FLAGS, "error code on a non-error result")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .kind           (out_ch.kind),
    .fin_bit        (out_ch.fin_bit),
    .frame_opcode   (out_ch.frame_opcode),
    .was_masked     (out_ch.was_masked),
    .payload_length (out_ch.payload_length),
    .data_byte      (out_ch.data_byte),
    .last           (out_ch.last),
    .error_code     (out_ch.error_code)
);

`default_nettype wire

// ===== tb/websocket_frame_deframer_test.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_test
// Self-checking bench for the WebSocket frame deframer. Byte streams of
// well-formed frames (all opcodes, short and 16-bit length forms, masked and
// unmasked) go in through the byte channel. Every result coming out is
// checked field by field against a cycle-free predictor of the parser.
// Traffic runs with and without source gaps and sink stalls under several
// register settings. The run ends on one randomly chosen protocol error,
// followed by bytes that must be dropped silently.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_test;
    import wsd_pkg::*;

    localparam int QUIET_LIMIT            = 2000;
    localparam int RANDOM_BYTES_PER_PHASE = 60;
    localparam int MAX_REPORTS            = 10;

    typedef enum logic [2:0] {
        PS_HDR0,
        PS_HDR1,
        PS_EXTLEN,
        PS_KEY,
        PS_PAYLOAD,
        PS_DEAD
    } parse_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    wsd_byte_if   in_ch();
    wsd_result_if out_ch();

    websocket_frame_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Register copies, as last written
    logic             cfg_mask_req = 1'b1;
    logic [LEN_W-1:0] cfg_max_len  = MAX_PAYLOAD_RST;

    // Parser state of the predictor
    parse_state_t     pstate = PS_HDR0;
    logic             m_fin = 1'b0;
    logic [3:0]       m_opcode = '0;
    logic             m_masked = 1'b0;
    logic [3:0]       m_len_left = '0;
    logic [63:0]      m_accum = '0;
    logic [7:0]       m_key [0:3];
    logic [2:0]       m_key_left = '0;
    logic [LEN_W-1:0] m_remaining = '0;
    logic [1:0]       m_key_idx = '0;
    logic             m_wide = 1'b0;

    wsd_result_t frame_results_due [$];

    int result_errors  = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic opcode_legal(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [LEN_W-1:0] plen,
                                 input logic [7:0] data, input logic last);
        wsd_result_t r;
        r.kind           = kind;
        r.fin_bit        = m_fin;
        r.frame_opcode   = m_opcode;
        r.was_masked     = m_masked;
        r.payload_length = plen;
        r.data_byte      = data;
        r.last           = last;
        r.error_code     = '0;
        frame_results_due = {frame_results_due, r};
    endfunction

    // Error results carry only kind and code; the parser goes dead.
    function automatic void flag_error(input logic [2:0] code);
        wsd_result_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        frame_results_due = {frame_results_due, r};
        pstate = PS_DEAD;
    endfunction

    function automatic void header_complete();
        if (m_opcode == OP_CLOSE && m_accum == 64'(CLOSE_BAD_LEN))
            flag_error(ERR_CLOSE_LEN);
        else
        begin
            emit(KIND_HEADER, m_accum[LEN_W-1:0], 8'h00, m_accum == 64'd0);
            m_remaining = m_accum[LEN_W-1:0];
            m_key_idx   = '0;
            pstate      = (m_remaining == '0) ? PS_HDR0 : PS_PAYLOAD;
        end
    endfunction

    function automatic void length_known();
        if (m_accum > {1'b0, cfg_max_len})
            flag_error(ERR_TOO_LARGE);
        else if (m_masked)
        begin
            m_key_left = 3'd4;
            pstate     = PS_KEY;
        end
        else
            header_complete();
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [6:0] marker;
        logic [7:0] d;
        case (pstate)
            PS_HDR0:
            begin
                m_fin    = b[7];
                m_opcode = b[3:0];
                m_masked = 1'b0;
                if (b[6:4] != 3'b000 || !opcode_legal(b[3:0]))
                    flag_error(ERR_FLAGS);
                else
                    pstate = PS_HDR1;
            end
            PS_HDR1:
            begin
                marker   = b[6:0];
                m_masked = b[7];
                if (cfg_mask_req && !m_masked)
                    flag_error(ERR_UNMASKED);
                else if (m_opcode[3] && (!m_fin || marker > MAX_CTRL_LEN))
                    flag_error(ERR_CONTROL);
                else
                begin
                    m_accum = '0;
                    if (marker >= LEN16_MARK)
                    begin
                        m_wide     = (marker == LEN64_MARK);
                        m_len_left = m_wide ? 4'd8 : 4'd2;
                        pstate     = PS_EXTLEN;
                    end
                    else
                    begin
                        m_accum = 64'(marker);
                        length_known();
                    end
                end
            end
            PS_EXTLEN:
            begin
                if (m_wide && m_len_left == 4'd8 && b[7])
                    flag_error(ERR_LEN_MSB);
                else
                begin
                    m_accum    = {m_accum[55:0], b};
                    m_len_left = m_len_left - 4'd1;
                    if (m_len_left == 4'd0)
                    begin
                        if ((!m_wide && m_accum < 64'(MIN_LEN16)) ||
                            (m_wide && m_accum <= 64'(MAX_LEN16)))
                            flag_error(ERR_NONCANON);
                        else
                            length_known();
                    end
                end
            end
            PS_KEY:
            begin
                m_key[2'(3'd4 - m_key_left)] = b;
                m_key_left = m_key_left - 3'd1;
                if (m_key_left == 3'd0)
                    header_complete();
            end
            PS_PAYLOAD:
            begin
                d           = m_masked ? (b ^ m_key[m_key_idx]) : b;
                m_key_idx   = m_key_idx + 2'd1;
                m_remaining = m_remaining - 1'b1;
                emit(KIND_PAYLOAD, '0, d, m_remaining == '0);
                if (m_remaining == '0)
                    pstate = PS_HDR0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_result(input wsd_result_t got);
        wsd_result_t want;
        if (frame_results_due.size() == 0)
        begin
            result_errors++;
            if (result_errors <= MAX_REPORTS)
                $display("unexpected result: kind %0d op %0h len %0h data %02h last %0d code %0d",
                         got.kind, got.frame_opcode, got.payload_length, got.data_byte,
                         got.last, got.error_code);
            return;
        end
        want = frame_results_due.pop_front();
        if (got.kind !== want.kind || got.fin_bit !== want.fin_bit ||
            got.frame_opcode !== want.frame_opcode || got.was_masked !== want.was_masked ||
            got.payload_length !== want.payload_length || got.data_byte !== want.data_byte ||
            got.last !== want.last || got.error_code !== want.error_code)
        begin
            result_errors++;
            if (result_errors <= MAX_REPORTS)
            begin
                $display("mismatch expected: kind %0d fin %0d op %0h mask %0d len %0h data %02h last %0d code %0d",
                         want.kind, want.fin_bit, want.frame_opcode, want.was_masked,
                         want.payload_length, want.data_byte, want.last, want.error_code);
                $display("         actual:   kind %0d fin %0d op %0h mask %0d len %0h data %02h last %0d code %0d",
                         got.kind, got.fin_bit, got.frame_opcode, got.was_masked,
                         got.payload_length, got.data_byte, got.last, got.error_code);
            end
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        wsd_result_t got;
        logic        moved;
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                deframe_byte(in_ch.in_byte);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind           = out_ch.kind;
                got.fin_bit        = out_ch.fin_bit;
                got.frame_opcode   = out_ch.frame_opcode;
                got.was_masked     = out_ch.was_masked;
                got.payload_length = out_ch.payload_length;
                got.data_byte      = out_ch.data_byte;
                got.last           = out_ch.last;
                got.error_code     = out_ch.error_code;
                check_result(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("websocket_frame_deframer_test: FAIL");
        $finish;
    end

    // Sink stalls at random, re-drawn every cycle
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold the source until every due result has been seen.
    task automatic hold_until_empty();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (frame_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Let bytes with no result settle before touching registers.
    task automatic drain();
        hold_until_empty();
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_REQUIRE_MASK)
            cfg_mask_req = data[0];
        else
            cfg_max_len = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] op_by_index(input int k);
        case (k)
            0: return OP_CONT;
            1: return OP_TEXT;
            2: return OP_BIN;
            3: return OP_CLOSE;
            4: return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
                               input longint unsigned len);
        int k;
        send_byte({fin, 3'b000, op});
        if (len <= 125)
            send_byte({masked, 7'(len)});
        else if (len <= 65535)
        begin
            send_byte({masked, LEN16_MARK});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else
        begin
            send_byte({masked, LEN64_MARK});
            for (k = 7; k >= 0; k--)
                send_byte(len[8*k +: 8]);
        end
    endtask

    // extremes: alternate all-zero and all-one bytes in key and payload
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input longint unsigned len, input bit extremes);
        int k;
        longint unsigned n;
        send_header(fin, op, masked, len);
        if (masked)
            for (k = 0; k < 4; k++)
                send_byte(extremes ? (k[0] ? 8'h00 : 8'hff) : 8'($urandom));
        for (n = 0; n < len; n++)
            send_byte(extremes ? (n[0] ? 8'hff : 8'h00) : 8'($urandom));
    endtask

    task automatic send_random_frame();
        int         pick;
        int         cap;
        int         len;
        logic [3:0] op;
        logic       fin;
        logic       masked;
        op     = op_by_index($urandom_range(0, 5));
        fin    = op[3] ? 1'b1 : 1'($urandom);
        masked = cfg_mask_req ? 1'b1 : 1'($urandom);
        cap    = op[3] ? 125 : 300;
        if (cfg_max_len < 63'(cap))
            cap = int'(cfg_max_len);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            len = $urandom_range(0, (cap < 20) ? cap : 20);
        else if (pick < 9)
            len = $urandom_range(0, (cap < 125) ? cap : 125);
        else
            len = $urandom_range(0, cap);
        if (op == OP_CLOSE && len == 1)
            len = (cap >= 2) ? 2 : 0;
        send_frame(fin, op, masked, len, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // reset settings: masking required
        send_frame(1'b1, OP_BIN, 1'b1, 4, 1'b1);
        drain();
        write_reg(CFG_REQUIRE_MASK, 63'd0);
        send_frame(1'b0, OP_TEXT, 1'b0, 1, 1'b1);
        send_frame(1'b1, OP_CONT, 1'b0, 0, 1'b1);
        send_frame(1'b1, OP_CLOSE, 1'b0, 0, 1'b1);
        send_frame(1'b1, OP_PING, 1'b0, 2, 1'b1);
        send_frame(1'b1, OP_PONG, 1'b1, 0, 1'b1);
    endtask

    task automatic test_length_forms();
        drain();
        write_reg(CFG_MAX_PAYLOAD, {LEN_W{1'b1}});
        src_idle_pct   = 31;
        sink_stall_pct = 31;
        send_frame(1'b1, OP_TEXT, 1'b1, 126, 1'b0);
        send_frame(1'b1, OP_PING, 1'b1, 125, 1'b0);
        send_frame(1'b1, OP_CLOSE, 1'b0, 2, 1'b1);
        send_frame(1'b1, OP_CONT, 1'b0, 130, 1'b0);
    endtask

    task automatic test_size_limit();
        int k;
        drain();
        write_reg(CFG_MAX_PAYLOAD, 63'd0);
        src_idle_pct   = 56;
        sink_stall_pct = 0;
        for (k = 0; k < 6; k++)
            send_frame(1'b1, op_by_index(k), k[0], 0, 1'b0);
        drain();
        write_reg(CFG_MAX_PAYLOAD, 63'd126);
        send_frame(1'b0, OP_BIN, 1'b1, 126, 1'b0);
        send_frame(1'b1, OP_CONT, 1'b0, 125, 1'b0);
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct,
                                    input logic mask_req, input logic [LEN_W-1:0] max_len,
                                    input bit pause_midway);
        int start;
        bit paused;
        drain();
        write_reg(CFG_REQUIRE_MASK, 63'(mask_req));
        write_reg(CFG_MAX_PAYLOAD, max_len);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES_PER_PHASE)
        begin
            send_random_frame();
            if (pause_midway && !paused && bytes_sent - start >= RANDOM_BYTES_PER_PHASE / 2)
            begin
                hold_until_empty();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 1'b0, {LEN_W{1'b1}}, 1'b0);
        run_random_phase(56, 0, 1'b1, MAX_PAYLOAD_RST, 1'b1);
        run_random_phase(0, 56, 1'b0, 63'($urandom_range(0, 40)), 1'b0);
        run_random_phase(31, 31, 1'($urandom), 63'($urandom_range(126, 250)), 1'b0);
    endtask

    // One error per run: the parser stays dead until reset.
    task automatic test_protocol_error();
        int              code;
        int              k;
        int              pick;
        logic            masked;
        logic [3:0]      op;
        longint unsigned len;
        code = $urandom_range(0, 6);
        drain();
        write_reg(CFG_REQUIRE_MASK, (code == 1) ? 63'd1 : 63'($urandom_range(0, 1)));
        // a limit near 65535 makes the oversize length take the 64-bit form
        if (code == 5)
            write_reg(CFG_MAX_PAYLOAD, $urandom_range(0, 1) ? 63'($urandom_range(0, 300))
                                                            : 63'($urandom_range(65535, 65835)));
        src_idle_pct   = 31;
        sink_stall_pct = 31;
        case (code)
            0:
            begin
                if ($urandom_range(0, 1))
                    send_byte({1'($urandom), 3'($urandom_range(1, 7)),
                               op_by_index($urandom_range(0, 5))});
                else
                begin
                    pick = $urandom_range(0, 9);
                    op   = (pick < 5) ? 4'(3 + pick) : 4'(6 + pick);
                    send_byte({1'($urandom), 3'b000, op});
                end
            end
            1:
            begin
                send_byte({1'b1, 3'b000, OP_TEXT});
                send_byte({1'b0, 7'($urandom)});
            end
            2:
            begin
                op = op_by_index($urandom_range(3, 5));
                if ($urandom_range(0, 1))
                begin
                    send_byte({1'b0, 3'b000, op});
                    send_byte({1'b1, 7'($urandom_range(0, 125))});
                end
                else
                begin
                    send_byte({1'b1, 3'b000, op});
                    send_byte({1'b1, 7'($urandom_range(126, 127))});
                end
            end
            3:
            begin
                send_byte({1'b1, 3'b000, OP_BIN});
                send_byte({1'b1, LEN64_MARK});
                send_byte(8'($urandom_range(128, 255)));
            end
            4:
            begin
                send_byte({1'b1, 3'b000, OP_BIN});
                if ($urandom_range(0, 1))
                begin
                    send_byte({1'b1, LEN16_MARK});
                    send_byte(8'h00);
                    send_byte(8'($urandom_range(0, 125)));
                end
                else
                begin
                    send_byte({1'b1, LEN64_MARK});
                    repeat (6) send_byte(8'h00);
                    send_byte(8'($urandom));
                    send_byte(8'($urandom));
                end
            end
            5:
            begin
                len = cfg_max_len + 1 + $urandom_range(0, 400);
                send_header(1'b1, OP_BIN, 1'b1, len);
            end
            default:
            begin
                masked = cfg_mask_req | 1'($urandom);
                send_header(1'b1, OP_CLOSE, masked, 1);
                if (masked)
                    for (k = 0; k < 4; k++)
                        send_byte(8'($urandom));
            end
        endcase
        // everything after the error must be dropped
        repeat (20) send_byte(8'($urandom));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        out_ch.ready  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_length_forms();
        test_size_limit();
        test_random_traffic();
        test_protocol_error();

        drain();
        repeat (8) @(negedge clk);
        if (result_errors == 0 && frame_results_due.size() == 0)
            $display("websocket_frame_deframer_test: PASS");
        else
            $display("websocket_frame_deframer_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wsd_pkg.sv
rtl/core/wsd_byte_if.sv
rtl/core/wsd_result_if.sv
rtl/core/wsd_parse.sv
rtl/core/wsd_queue.sv
rtl/core/websocket_frame_deframer.sv
rtl/core/wsd_checker.sv
tb/websocket_frame_deframer_test.sv
